// ----- rtl/rgbhsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhsi_pkg: shared types and constants for the RGB to HSI converter
// Pixel and result structs, CORDIC arctangent table, fixed-point constants.
// ----------------------------------------------------------------------------
package rgbhsi_pkg;

   localparam int ANGLE_STAGES_DEF    = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int TABLE_SIZE          = 24;
   localparam int SQRT3_Q15           = 56756;
   localparam logic [7:0] GRAY_HUE    = 8'd63;

   // saturation quotient bits, one resolved per cell in the first cells
   localparam int SAT_STEPS = 8;

   // vector width: |x| <= 510*2^15 < 2^24, y <= 255*56756 < 2^24, growth ~1.65
   localparam int VEC_W = 27;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] intensity;
   } result_type;

   // Side data travelling with the vector through the cell row
   typedef struct packed {
      logic        gray;
      logic        flip;
      logic [7:0]  sat;
      logic [17:0] rem;
      logic [9:0]  dvs;
      logic [7:0]  inten;
   } side_type;

   localparam logic [31:0] ATAN_TURNS32 [TABLE_SIZE] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Table entry rounded half up to frac_bits fraction bits
   function automatic logic [31:0] table_angle(input int idx, input int frac_bits);
      logic [32:0] t;
      int          sh;
      sh = 32 - frac_bits;
      t  = {1'b0, ATAN_TURNS32[idx]} + (33'd1 << (sh - 1));
      return 32'(t >> sh);
   endfunction

endpackage

// ----- rtl/rgbhsi_front.sv -----
// ----------------------------------------------------------------------------
// rgbhsi_front: entry stage
// Forms the CORDIC start vector, intensity and the saturation dividend,
// one pixel a cycle while enabled.
// ----------------------------------------------------------------------------
module rgbhsi_front import rgbhsi_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int ZW              = ANGLE_FRAC_BITS + 2
) (
   input  logic                    clock,
   input  logic                    en,
   input  pixel_type               pix,
   output logic signed [VEC_W-1:0] x_out,
   output logic signed [VEC_W-1:0] y_out,
   output logic signed [ZW-1:0]    z_out,
   output side_type                side_out
);

   logic [9:0]  sum;
   logic [7:0]  mn;
   logic [9:0]  spread;
   logic [17:0] num;
   logic [7:0]  d;
   logic signed [10:0]      xi;
   logic signed [VEC_W-1:0] x0, y0, xr, yr;
   logic signed [ZW-1:0]    zr;

   logic signed [VEC_W-1:0] x_ff, y_ff;
   logic signed [ZW-1:0]    z_ff;
   side_type                side_ff, side_in;

   always_comb begin
      sum = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
      mn  = pix.red;
      if (pix.green < mn) mn = pix.green;
      if (pix.blue < mn) mn = pix.blue;
      spread = sum - 10'(3 * mn);
      num    = 18'(255) * 18'(spread);
      // quotient bits are resolved one per cell down the row
      side_in.sat   = '0;
      side_in.rem   = num;
      side_in.dvs   = sum;
      side_in.inten = 8'((19'(sum) * 19'd683) >> 11);
      side_in.gray  = (pix.red == pix.green) && (pix.green == pix.blue);
      side_in.flip  = pix.blue > pix.green;
      d  = (pix.green >= pix.blue) ? pix.green - pix.blue : pix.blue - pix.green;
      xi = 11'sd2 * $signed({3'b0, pix.red}) - $signed({3'b0, pix.green})
           - $signed({3'b0, pix.blue});
      x0 = VEC_W'(xi) <<< 15;
      y0 = $signed(VEC_W'(d) * VEC_W'(SQRT3_Q15));
      // pre-rotate by a quarter turn for the left half plane
      if (x0 < 0) begin
         xr = y0;
         yr = -x0;
         zr = ZW'(1) <<< (ANGLE_FRAC_BITS - 2);
      end else begin
         xr = x0;
         yr = y0;
         zr = '0;
      end
   end

   // Register the entry stage
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= xr;
         y_ff    <= yr;
         z_ff    <= zr;
         side_ff <= side_in;
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign side_out = side_ff;

endmodule

// ----- rtl/rgbhsi_cell.sv -----
// ----------------------------------------------------------------------------
// rgbhsi_cell: one CORDIC vectoring cell
// Rotates the vector by one table angle, resolves one saturation quotient
// bit in the first cells, and hands everything to the next cell.
// ----------------------------------------------------------------------------
module rgbhsi_cell import rgbhsi_pkg::*; #(
   parameter int IDX             = 0,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int ZW              = ANGLE_FRAC_BITS + 2
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VEC_W-1:0] x_in,
   input  logic signed [VEC_W-1:0] y_in,
   input  logic signed [ZW-1:0]    z_in,
   input  side_type                side_in,
   output logic signed [VEC_W-1:0] x_out,
   output logic signed [VEC_W-1:0] y_out,
   output logic signed [ZW-1:0]    z_out,
   output side_type                side_out
);

   localparam logic signed [ZW-1:0] ANG = (IDX < TABLE_SIZE) ?
      ZW'(table_angle(IDX, ANGLE_FRAC_BITS)) : '0;
   localparam int QBIT = (IDX < SAT_STEPS) ? SAT_STEPS - 1 - IDX : 0;

   logic signed [VEC_W-1:0] x_ff, y_ff, dx, dy;
   logic signed [ZW-1:0]    z_ff;
   side_type                side_ff, side_nx;
   logic [17:0]             part;

   assign dx = y_in >>> IDX;
   assign dy = x_in >>> IDX;

   // Resolve one restoring-division bit of the saturation quotient
   always_comb begin
      side_nx = side_in;
      part    = 18'(side_in.dvs) << QBIT;
      if (IDX < SAT_STEPS && side_in.dvs != 10'd0 && side_in.rem >= part) begin
         side_nx.rem = side_in.rem - part;
         side_nx.sat = side_in.sat | (8'd1 << QBIT);
      end
   end

   // Advance one micro-rotation; cells past the table pass data unchanged
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_nx;
         if (IDX >= TABLE_SIZE) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
         end else if (y_in >= 0) begin
            x_ff <= x_in + dx;
            y_ff <= y_in - dy;
            z_ff <= z_in + ANG;
         end else begin
            x_ff <= x_in - dx;
            y_ff <= y_in + dy;
            z_ff <= z_in - ANG;
         end
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign side_out = side_ff;

endmodule

// ----- rtl/rgb_to_hsi_pixel_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel_converter: streaming RGB to HSI conversion
// Entry stage, a row of CORDIC cells and a hue scaling stage.
//
//   channel  dir  payload      handshake
//   req_     in   pixel_type   req_valid / req_ready
//   rsp_     out  result_type  rsp_valid / rsp_ready
//
// One pixel per clock while the output is not stalled. Registered stages:
// entry stage, one per CORDIC cell, output register. The whole row advances
// together; a stalled output halts it. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rgb_to_hsi_pixel_converter import rgbhsi_pkg::*; #(
   parameter int ANGLE_STAGES    = ANGLE_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  pixel_type  req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   localparam int ZW = ANGLE_FRAC_BITS + 2;
   localparam int N  = ANGLE_STAGES;

   logic signed [VEC_W-1:0] xs [N+1];
   logic signed [VEC_W-1:0] ys [N+1];
   logic signed [ZW-1:0]    zs [N+1];
   side_type                ss [N+1];
   logic [N+1:0]            vld_ff, vld_in;
   logic                    en;
   result_type              rsp_ff, rsp_in;
   logic signed [ZW-1:0]    zc;
   logic [ZW-1:0]           h;
   logic [ZW+7:0]           q;

   // Advance when the output slot is empty or being drained
   assign en        = !vld_ff[N+1] || rsp_ready;
   assign req_ready = en;

   rgbhsi_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ZW(ZW)) u_front (
      .clock(clock), .en(en), .pix(req_data),
      .x_out(xs[0]), .y_out(ys[0]), .z_out(zs[0]), .side_out(ss[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      rgbhsi_cell #(.IDX(i), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ZW(ZW)) u_cell (
         .clock(clock), .en(en),
         .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]), .side_in(ss[i]),
         .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]), .side_out(ss[i+1])
      );
   end

   // Clamp angle, mirror for blue above green, scale to 256 steps
   always_comb begin
      zc = zs[N];
      if (zc < 0) zc = '0;
      if (zc > (ZW'(1) <<< (ANGLE_FRAC_BITS - 1))) zc = ZW'(1) <<< (ANGLE_FRAC_BITS - 1);
      h = ss[N].flip ? (ZW'(1) << ANGLE_FRAC_BITS) - ZW'(zc) : ZW'(zc);
      q = ((ZW + 8)'(h) * (ZW + 8)'(255)) >> ANGLE_FRAC_BITS;
      rsp_in.hue        = ss[N].gray ? GRAY_HUE : ((q > 255) ? 8'd255 : 8'(q));
      rsp_in.saturation = ss[N].sat;
      rsp_in.intensity  = ss[N].inten;
      vld_in            = {vld_ff[N:0], req_valid};
   end

   // Hold valid bits and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[N+1];
   assign rsp_data  = rsp_ff;

endmodule
